// ===== design/crrm_pkg.sv =====
// Package with the shared types, constants and codes of the capture ring record manager.
`default_nettype none
package crrm_pkg;
  localparam int BufferBytes = 65536;
  localparam int AlignBytes = 8;
  localparam int HeaderBytes = 16;
  localparam int MaxCapture = 16384;
  localparam int StoreDepth = BufferBytes / AlignBytes;
  localparam int StoreAw = $clog2(StoreDepth);
  localparam int AlignSh = $clog2(AlignBytes);
  localparam int PtrW = 17;

  localparam logic [1:0] RegWrapMode = 2'd0;
  localparam logic [1:0] RegMaxCap = 2'd1;
  localparam logic [1:0] RegBufLimit = 2'd2;

  localparam logic [1:0] DirReceive = 2'd1;
  localparam logic [1:0] DirTransmit = 2'd2;

  typedef struct packed {
    logic [15:0] packet_length;
    logic is_transmit;
    logic [63:0] time_stamp;
    logic last_in_burst;
  } in_item_t;

  typedef struct packed {
    logic accepted;
    logic [15:0] record_address;
    logic [14:0] captured_length;
    logic [15:0] original_length;
    logic [1:0] direction_code;
    logic [63:0] stamp_out;
    logic [12:0] evicted_records;
    logic [12:0] total_packets;
    logic [16:0] total_bytes;
    logic burst_end;
  } out_item_t;

  typedef enum logic [2:0] {
    StIdle, StDecide, StWalkA, StCheck, StWalkB, StFinish, StRead
  } state_e;

  typedef struct packed {
    logic load;
    logic decide;
    logic wrap_reset;
    logic walk_a_step;
    logic check;
    logic walk_b_step;
    logic walk_b_stop;
    logic finish;
    logic issue_read;
  } ctrl_t;

  typedef struct packed {
    logic linear;
    logic need_wrap;
    logic walk_a_needed;
    logic walk_a_more;
    logic walk_b_needed;
    logic walk_b_done;
    logic walk_b_hit_end;
  } stat_t;

  function automatic logic [PtrW-1:0] rec_size(input logic [14:0] cap);
    logic [PtrW-1:0] c;
    c = {{(PtrW-15){1'b0}}, cap};
    rec_size = PtrW'(HeaderBytes) + ((c + PtrW'(AlignBytes - 1)) & ~PtrW'(AlignBytes - 1));
  endfunction
endpackage
`default_nettype wire

// ===== design/crrm_ctrl.sv =====
// Controller state machine that sequences one descriptor through placement and eviction.
`default_nettype none
module crrm_ctrl (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire crrm_pkg::stat_t stat_i,
  output crrm_pkg::ctrl_t ctrl_o,
  output logic busy_o
);
  import crrm_pkg::*;
  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o = '0;
    busy_o = (state_q != StIdle);
    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          state_d = StDecide;
        end
      end
      StDecide: begin
        ctrl_o.decide = 1'b1;
        if (stat_i.linear || !stat_i.need_wrap) begin
          state_d = StCheck;
        end else if (stat_i.walk_a_needed) begin
          ctrl_o.issue_read = 1'b1;
          state_d = StRead;
        end else begin
          ctrl_o.wrap_reset = 1'b1;
          state_d = StCheck;
        end
      end
      StRead: begin
        state_d = StWalkA;
      end
      StWalkA: begin
        ctrl_o.walk_a_step = 1'b1;
        if (stat_i.walk_a_more) begin
          ctrl_o.issue_read = 1'b1;
        end else begin
          ctrl_o.wrap_reset = 1'b1;
          state_d = StCheck;
        end
      end
      StCheck: begin
        ctrl_o.check = 1'b1;
        if (stat_i.walk_b_needed) begin
          ctrl_o.issue_read = 1'b1;
          state_d = StWalkB;
        end else begin
          state_d = StFinish;
        end
      end
      StWalkB: begin
        if (stat_i.walk_b_done) begin
          state_d = StFinish;
        end else if (stat_i.walk_b_hit_end) begin
          ctrl_o.walk_b_stop = 1'b1;
          state_d = StFinish;
        end else begin
          ctrl_o.walk_b_step = 1'b1;
          ctrl_o.issue_read = 1'b1;
        end
      end
      StFinish: begin
        ctrl_o.finish = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end
endmodule
`default_nettype wire

// ===== design/crrm_datapath.sv =====
// Datapath with the pointers, totals, record length store and result register.
`default_nettype none
module crrm_datapath (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire crrm_pkg::ctrl_t ctrl_i,
  input  wire crrm_pkg::in_item_t item_i,
  input  wire logic wrap_mode_i,
  input  wire logic [14:0] max_cap_i,
  input  wire logic [16:0] buf_limit_i,
  output crrm_pkg::stat_t stat_o,
  output crrm_pkg::out_item_t res_o,
  output logic res_valid_o
);
  import crrm_pkg::*;

  logic [PtrW-1:0] wp_q, oldest_q, wend_q;
  logic wrapped_q, full_q;
  logic [12:0] pk_tot_q;
  logic [16:0] by_tot_q;
  in_item_t item_q;
  logic [14:0] cap_q;
  logic [PtrW-1:0] total_q;
  logic ok_q;
  logic [12:0] evict_q;
  logic [PtrW-1:0] p_q, avail_q;
  logic [14:0] mem_q [StoreDepth];
  logic [14:0] rd_q;
  logic [PtrW-1:0] rd_addr;
  out_item_t res_q;
  logic res_valid_q;

  logic [14:0] lim, cap;
  logic [PtrW-1:0] endv, rsz, tot_c;
  logic [PtrW:0] wp_sum, hdr_sum;
  logic ovf;

  always_comb begin
    lim = (max_cap_i < 15'(MaxCapture)) ? max_cap_i : 15'(MaxCapture);
    cap = ({1'b0, item_q.packet_length} < {2'b0, lim}) ? item_q.packet_length[14:0] : lim;
    endv = (buf_limit_i < PtrW'(BufferBytes)) ? buf_limit_i : PtrW'(BufferBytes);
    endv = endv & ~PtrW'(AlignBytes - 1);
    tot_c = rec_size(cap);
    rsz = rec_size(rd_q);
    wp_sum = {1'b0, wp_q} + {1'b0, tot_c};
    ovf = wp_sum > {1'b0, endv};
    hdr_sum = {1'b0, p_q} + (PtrW+1)'(HeaderBytes);
    stat_o.linear = !wrap_mode_i;
    stat_o.need_wrap = ovf && (tot_c <= endv);
    stat_o.walk_a_needed = wrapped_q && (oldest_q != '0) && (oldest_q < wend_q);
    stat_o.walk_a_more = (p_q + rsz) < wend_q;
    stat_o.walk_b_needed = ok_q && wrap_mode_i && wrapped_q && (wp_q <= oldest_q)
                           && ((oldest_q - wp_q) < total_q);
    stat_o.walk_b_done = avail_q >= total_q;
    stat_o.walk_b_hit_end = hdr_sum > {1'b0, wend_q};
    rd_addr = ctrl_i.walk_a_step || ctrl_i.walk_b_step ? p_q + rsz : p_q;
    if (ctrl_i.decide || ctrl_i.check) rd_addr = oldest_q;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.issue_read) begin
      rd_q <= mem_q[rd_addr[AlignSh +: StoreAw]];
    end
    if (ctrl_i.finish && ok_q) begin
      mem_q[wp_q[AlignSh +: StoreAw]] <= cap_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      oldest_q <= '0;
      wend_q <= '0;
      wrapped_q <= 1'b0;
      full_q <= 1'b0;
      pk_tot_q <= '0;
      by_tot_q <= '0;
      ok_q <= 1'b0;
      res_valid_q <= 1'b0;
      evict_q <= '0;
      p_q <= '0;
      avail_q <= '0;
    end else begin
      res_valid_q <= ctrl_i.finish;
      if (ctrl_i.load) begin
        evict_q <= '0;
      end
      if (ctrl_i.decide) begin
        if (!wrap_mode_i) begin
          if (full_q) begin
            ok_q <= 1'b0;
          end else if (ovf) begin
            full_q <= 1'b1;
            ok_q <= 1'b0;
          end else begin
            ok_q <= 1'b1;
          end
        end else begin
          ok_q <= tot_c <= endv;
        end
        p_q <= oldest_q;
      end
      if (ctrl_i.walk_a_step) begin
        p_q <= p_q + rsz;
        pk_tot_q <= pk_tot_q - 13'd1;
        by_tot_q <= by_tot_q - 17'(rd_q);
        evict_q <= evict_q + 13'd1;
      end
      if (ctrl_i.wrap_reset) begin
        oldest_q <= '0;
        wend_q <= wp_q;
        wp_q <= '0;
        wrapped_q <= 1'b1;
      end
      if (ctrl_i.check) begin
        p_q <= oldest_q;
        avail_q <= oldest_q - wp_q;
      end
      if (ctrl_i.walk_b_step) begin
        avail_q <= avail_q + rsz;
        p_q <= p_q + rsz;
        oldest_q <= p_q + rsz;
        pk_tot_q <= pk_tot_q - 13'd1;
        by_tot_q <= by_tot_q - 17'(rd_q);
        evict_q <= evict_q + 13'd1;
      end
      if (ctrl_i.walk_b_stop) begin
        oldest_q <= '0;
      end
      if (ctrl_i.finish && ok_q) begin
        wp_q <= wp_q + total_q;
        pk_tot_q <= pk_tot_q + 13'd1;
        by_tot_q <= by_tot_q + 17'(cap_q);
      end
    end
  end

  // The walk in the decide state is only started when wrap mode accepts the record.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      item_q <= item_i;
    end
    if (ctrl_i.decide) begin
      cap_q <= cap;
      total_q <= tot_c;
    end
    if (ctrl_i.finish) begin
      res_q.accepted <= ok_q;
      res_q.record_address <= ok_q ? wp_q[15:0] : 16'd0;
      res_q.captured_length <= cap_q;
      res_q.original_length <= item_q.packet_length;
      res_q.direction_code <= item_q.is_transmit ? DirTransmit : DirReceive;
      res_q.stamp_out <= item_q.time_stamp;
      res_q.evicted_records <= ok_q ? evict_q : 13'd0;
      res_q.total_packets <= ok_q ? pk_tot_q + 13'd1 : pk_tot_q;
      res_q.total_bytes <= ok_q ? by_tot_q + 17'(cap_q) : by_tot_q;
      res_q.burst_end <= item_q.last_in_burst;
    end
  end

  assign res_o = res_q;
  assign res_valid_o = res_valid_q;
endmodule
`default_nettype wire

// ===== design/capture_ring_record_manager.sv =====
// Top level of the capture ring record manager with its register port.
`default_nettype none
// One descriptor is accepted when start_i is high and busy_o is low; its result
// appears for one cycle with done_o high and cannot be held off. A record that
// needs no eviction passes through the decide, check and finish states before its
// result; each evicted record adds a walk step, since the eviction walk reads the record
// length store once per cycle, and a walk from the decide state first passes a read state.
module capture_ring_record_manager (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  output logic busy_o,
  input  wire crrm_pkg::in_item_t item_i,
  output logic done_o,
  output crrm_pkg::out_item_t result_o,
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [3:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import crrm_pkg::*;
  logic wrap_q;
  logic [14:0] maxcap_q;
  logic [16:0] limit_q;
  ctrl_t ctrl;
  stat_t stat;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q <= 1'b0;
      maxcap_q <= 15'(MaxCapture);
      limit_q <= 17'(BufferBytes);
    end else if (wr && paddr[1:0] == 2'd0) begin
      unique case (paddr[3:2])
        RegWrapMode: wrap_q <= pwdata[0];
        RegMaxCap: maxcap_q <= pwdata[14:0];
        RegBufLimit: limit_q <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      RegWrapMode: prdata = {31'd0, wrap_q};
      RegMaxCap: prdata = {17'd0, maxcap_q};
      RegBufLimit: prdata = {15'd0, limit_q};
      default: prdata = '0;
    endcase
  end

  crrm_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i),
    .stat_i(stat), .ctrl_o(ctrl), .busy_o(busy_o)
  );

  crrm_datapath u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .ctrl_i(ctrl), .item_i(item_i),
    .wrap_mode_i(wrap_q), .max_cap_i(maxcap_q), .buf_limit_i(limit_q),
    .stat_o(stat), .res_o(result_o), .res_valid_o(done_o)
  );

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("result without work");
  a_no_done_idle_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> !done_o) else $error("result right after accept");
  a_drop_no_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.accepted) |-> (result_o.evicted_records == '0))
    else $error("dropped record evicted");
endmodule
`default_nettype wire

// ===== test/capture_ring_record_manager_tb.sv =====
// Self-checking testbench for the capture ring record manager, with predictor, driver and monitor.
`default_nettype none
module capture_ring_record_manager_tb;
  import crrm_pkg::*;

  localparam int unsigned StallLimit = 50000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  in_item_t item_i = '0;
  logic done_o;
  out_item_t result_o;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  capture_ring_record_manager DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .item_i(item_i),
    .done_o(done_o), .result_o(result_o), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state.
  logic cfg_wrap;
  logic [14:0] cfg_max_cap;
  logic [16:0] cfg_limit;
  int unsigned wr_ptr, old_ptr, lap_end;
  logic lapped, stopped;
  logic [12:0] held_packets;
  logic [16:0] held_bytes;
  logic [14:0] cap_store [0:StoreDepth-1];

  in_item_t pending_descs[$];
  out_item_t expected_records[$];
  bit failed = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  int unsigned quiet_cycles = 0;

  function automatic int unsigned record_bytes(int unsigned cap);
    return HeaderBytes + ((cap + AlignBytes - 1) / AlignBytes) * AlignBytes;
  endfunction

  function automatic out_item_t place_record(in_item_t d);
    out_item_t r;
    int unsigned lim, cap, total, end_b, p, pk, by, c, avail, evicted;
    bit ok;
    lim = (cfg_max_cap < MaxCapture) ? cfg_max_cap : MaxCapture;
    cap = (d.packet_length < lim) ? d.packet_length : lim;
    total = record_bytes(cap);
    end_b = (cfg_limit < BufferBytes) ? cfg_limit : BufferBytes;
    end_b = end_b - end_b % AlignBytes;
    ok = 1'b0;
    evicted = 0;
    if (!cfg_wrap) begin
      if (!stopped) begin
        if (wr_ptr + total > end_b) stopped = 1'b1;
        else ok = 1'b1;
      end
    end else if (total <= end_b) begin
      ok = 1'b1;
      if (wr_ptr + total > end_b) begin
        if (lapped && old_ptr > 0) begin
          p = old_ptr;
          pk = 0;
          by = 0;
          while (p < lap_end) begin
            c = cap_store[(p / AlignBytes) % StoreDepth];
            pk++;
            by += c;
            p += record_bytes(c);
          end
          held_packets -= 13'(pk);
          held_bytes -= 17'(by);
          evicted += pk;
        end
        old_ptr = 0;
        lap_end = wr_ptr;
        wr_ptr = 0;
        lapped = 1'b1;
      end
      if (lapped && wr_ptr <= old_ptr) begin
        avail = old_ptr - wr_ptr;
        p = old_ptr;
        pk = 0;
        by = 0;
        while (avail < total) begin
          if (p + HeaderBytes > lap_end) begin
            p = 0;
            break;
          end
          c = cap_store[(p / AlignBytes) % StoreDepth];
          avail += record_bytes(c);
          pk++;
          by += c;
          p += record_bytes(c);
        end
        old_ptr = p;
        held_packets -= 13'(pk);
        held_bytes -= 17'(by);
        evicted += pk;
      end
    end
    r = '0;
    if (ok) begin
      r.record_address = 16'(wr_ptr);
      cap_store[(wr_ptr / AlignBytes) % StoreDepth] = 15'(cap);
      wr_ptr += total;
      held_packets += 13'd1;
      held_bytes += 17'(cap);
      r.evicted_records = 13'(evicted);
    end
    r.accepted = ok;
    r.captured_length = 15'(cap);
    r.original_length = d.packet_length;
    r.direction_code = d.is_transmit ? DirTransmit : DirReceive;
    r.stamp_out = d.time_stamp;
    r.total_packets = held_packets;
    r.total_bytes = held_bytes;
    r.burst_end = d.last_in_burst;
    return r;
  endfunction

  // Driver: bursts of beats separated by random gaps.
  always @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      expected_records.push_back(place_record(item_i));
    end
    if (!start_i || !busy_o) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start_i <= 1'b0;
      end else if (rst_ni && pending_descs.size() > 0) begin
        item_i <= pending_descs.pop_front();
        start_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 16);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      failed = 1'b1;
    end
  endtask

  // Monitor.
  always @(posedge clk_i) begin
    out_item_t e;
    if (rst_ni && done_o) begin
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %p", $time, result_o);
        failed = 1'b1;
      end else begin
        e = expected_records.pop_front();
        check_field("accepted", e.accepted, result_o.accepted);
        check_field("record_address", e.record_address, result_o.record_address);
        check_field("captured_length", e.captured_length, result_o.captured_length);
        check_field("original_length", e.original_length, result_o.original_length);
        check_field("direction_code", e.direction_code, result_o.direction_code);
        check_field("stamp_out", e.stamp_out, result_o.stamp_out);
        check_field("evicted_records", e.evicted_records, result_o.evicted_records);
        check_field("total_packets", e.total_packets, result_o.total_packets);
        check_field("total_bytes", e.total_bytes, result_o.total_bytes);
        check_field("burst_end", e.burst_end, result_o.burst_end);
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("capture_ring_record_manager regression: fail");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegWrapMode: cfg_wrap = value[0];
      RegMaxCap: cfg_max_cap = value[14:0];
      RegBufLimit: cfg_limit = value[16:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    while (pending_descs.size() > 0 || expected_records.size() > 0 || start_i || busy_o)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic add_desc(logic [15:0] len, logic tx, logic [63:0] stamp, logic last);
    in_item_t d;
    d.packet_length = len;
    d.is_transmit = tx;
    d.time_stamp = stamp;
    d.last_in_burst = last;
    pending_descs.push_back(d);
  endtask

  task automatic add_random(int unsigned count, int unsigned short_max);
    logic [15:0] len;
    repeat (count) begin
      case ($urandom_range(0, 9))
        0: len = 16'($urandom_range(0, 65535));
        1: len = 16'($urandom_range(16380, 16390));
        2: len = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'hFFFF;
        default: len = 16'($urandom_range(0, short_max));
      endcase
      add_desc(len, 1'($urandom), {$urandom, $urandom}, 1'($urandom));
    end
  endtask

  initial begin
    cfg_wrap = 1'b0;
    cfg_max_cap = 15'd16384;
    cfg_limit = 17'd65536;
    wr_ptr = 0;
    old_ptr = 0;
    lap_end = 0;
    lapped = 1'b0;
    stopped = 1'b0;
    held_packets = '0;
    held_bytes = '0;
    foreach (cap_store[i]) cap_store[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Linear mode: edge lengths, then fill until the buffer is full.
    reg_write(RegWrapMode, 32'd0);
    reg_write(RegMaxCap, 32'd16384);
    reg_write(RegBufLimit, 32'd65536);
    add_desc(16'd0, 1'b0, 64'd0, 1'b0);
    add_desc(16'd1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    add_desc(16'd7, 1'b0, 64'h5555_5555_5555_5555, 1'b0);
    add_desc(16'd8, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    add_desc(16'd9, 1'b0, 64'd1, 1'b0);
    add_desc(16'd16384, 1'b1, 64'h8000_0000_0000_0000, 1'b0);
    add_desc(16'd16385, 1'b0, 64'd2, 1'b1);
    add_desc(16'hFFFF, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    add_desc(16'hFFFF, 1'b0, 64'd3, 1'b0);
    add_desc(16'd0, 1'b1, 64'd4, 1'b1);
    add_desc(16'h5555, 1'b0, 64'd5, 1'b0);
    add_desc(16'hAAAA, 1'b1, 64'd6, 1'b1);
    wait_idle();

    // Wrap mode with the full buffer.
    reg_write(RegWrapMode, 32'd1);
    add_random(280, 300);
    wait_idle();

    // Capture limit above the maximum and a limit that is not aligned.
    reg_write(RegMaxCap, 32'd32767);
    reg_write(RegBufLimit, 32'd4099);
    add_random(150, 400);
    wait_idle();

    // Smallest buffer: larger records are dropped as too large.
    reg_write(RegMaxCap, 32'd100);
    reg_write(RegBufLimit, 32'd64);
    add_desc(16'd100, 1'b0, 64'd7, 1'b1);
    add_desc(16'd40, 1'b1, 64'd8, 1'b0);
    add_random(100, 60);
    wait_idle();

    // Smallest capture limit with the limit register above the buffer.
    reg_write(RegMaxCap, 32'd1);
    reg_write(RegBufLimit, 32'd131071);
    add_random(60, 300);
    wait_idle();

    reg_write(RegMaxCap, 32'd16384);
    add_random(120, 200);
    wait_idle();

    repeat (20) @(posedge clk_i);
    if (!failed) begin
      $display("capture_ring_record_manager regression: pass");
    end else begin
      $display("capture_ring_record_manager regression: fail");
    end
    $finish;
  end
endmodule
`default_nettype wire
